### rtl/rwts_pkg.sv
// ----------------------------------------------------------------------------
// rwts_pkg: shared types and constants of the wall texel shader
// Texture geometry, field codes and the front-to-back queue item.
// ----------------------------------------------------------------------------
package rwts_pkg;

  localparam int unsigned TEX_BITS    = 6;
  localparam int unsigned TEX_SIZE    = 1 << TEX_BITS;
  localparam int unsigned SIDE_BITS   = 2;
  localparam int unsigned ADDR_W      = SIDE_BITS + 2 * TEX_BITS;
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
  localparam int unsigned COLOR_BITS  = 32;
  localparam int unsigned H_BITS      = 16;
  localparam int unsigned ROWS_BITS   = 13;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [H_BITS-1:0] HEIGHT_MAX = '1;

  localparam logic FUNC_TEXEL = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_S = 2'd1;
  localparam logic [1:0] SIDE_W = 2'd2;
  localparam logic [1:0] SIDE_E = 2'd3;

  localparam logic CFG_HEIGHT_SCALE = 1'b0;
  localparam logic CFG_SCREEN_ROWS  = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [11:0]           column;
    logic [11:0]           row;
    logic [SIDE_BITS-1:0]  side;
    logic [TEX_BITS-1:0]   tx;
    logic [2*TEX_BITS-1:0] taddr;
    logic [COLOR_BITS-1:0] tcolor;
    logic [H_BITS-1:0]     h;
  } qitem_t;

endpackage

### rtl/raycast_wall_texel_shader.sv
// ----------------------------------------------------------------------------
// raycast_wall_texel_shader: textured wall shading for a raycaster
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the queue is not full. A pixel beat passes
// the height divider (17 stages: an input register, then one quotient bit
// each), the queue, 8 back stages for the span test and the six-bit texture
// y divider, and the store read plus output register that holds its result.
// A texel write beat passes the same path and gives no result. The front
// holds off intake only while the four-entry queue is full.
module raycast_wall_texel_shader
  import rwts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  // column[11:0] row[23:12] distance[55:24] hit_frac_x[71:56] hit_frac_y[87:72]
  // wall_side[89:88] texel_addr[101:90] texel_color[133:102], zero pad
  input  logic [135:0] s_tdata,
  // func[0]
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_column[11:0] out_row[23:12] in_wall[24] color[56:25], zero pad
  output logic [63:0]  m_tdata
);

  logic [31:0]          hs_q;
  logic [ROWS_BITS-1:0] rows_q;
  logic                 push, pop, q_empty, q_full;
  qitem_t               push_item, head;
  logic [11:0]          o_col, o_row;
  logic                 o_inw;
  logic [COLOR_BITS-1:0] o_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q   <= 32'd31457280;
      rows_q <= ROWS_BITS'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEIGHT_SCALE: hs_q   <= cfg_data_i;
        CFG_SCREEN_ROWS:  rows_q <= cfg_data_i[ROWS_BITS-1:0];
        default: ;
      endcase
    end
  end

  rwts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .height_scale_i (hs_q),
    .in_valid_i     (s_tvalid),
    .in_ready_o     (s_tready),
    .func_i         (s_tuser[0]),
    .column_i       (s_tdata[11:0]),
    .row_i          (s_tdata[23:12]),
    .distance_i     (s_tdata[55:24]),
    .hit_frac_x_i   (s_tdata[71:56]),
    .hit_frac_y_i   (s_tdata[87:72]),
    .wall_side_i    (s_tdata[89:88]),
    .texel_addr_i   (s_tdata[101:90]),
    .texel_color_i  (s_tdata[133:102]),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  rwts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  rwts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .screen_rows_i (rows_q),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_column_o  (o_col),
    .out_row_o     (o_row),
    .in_wall_o     (o_inw),
    .color_o       (o_color)
  );

  assign m_tdata = {7'b0, o_color, o_inw, o_row, o_col};

endmodule

### rtl/rwts_front.sv
// ----------------------------------------------------------------------------
// rwts_front: beat intake and wall height divider
// Classifies beats, picks texture x and runs height_scale/distance, one bit
// per stage, then pushes a queue item.
// ----------------------------------------------------------------------------
module rwts_front
  import rwts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           height_scale_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [11:0]           column_i,
  input  logic [11:0]           row_i,
  input  logic [31:0]           distance_i,
  input  logic [15:0]           hit_frac_x_i,
  input  logic [15:0]           hit_frac_y_i,
  input  logic [SIDE_BITS-1:0]  wall_side_i,
  input  logic [2*TEX_BITS-1:0] texel_addr_i,
  input  logic [COLOR_BITS-1:0] texel_color_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output qitem_t                push_item_o
);

  typedef struct packed {
    logic                  func;
    logic [11:0]           column;
    logic [11:0]           row;
    logic [SIDE_BITS-1:0]  side;
    logic [TEX_BITS-1:0]   tx;
    logic [2*TEX_BITS-1:0] taddr;
    logic [COLOR_BITS-1:0] tcolor;
    logic [31:0]           divisor;
    logic [H_BITS-1:0]     num;
    logic [31:0]           rem;
    logic [H_BITS-1:0]     q;
    logic                  sat;
  } fstage_t;

  fstage_t st_q [0:H_BITS];
  fstage_t st0_d;
  logic [H_BITS:0] vld_q;
  logic    en;
  logic [15:0] frac;
  logic [TEX_BITS-1:0] tx_raw;

  assign en         = !q_full_i;
  assign in_ready_o = en;

  always_comb begin
    frac   = (wall_side_i == SIDE_W || wall_side_i == SIDE_E) ? hit_frac_y_i : hit_frac_x_i;
    tx_raw = frac[15 -: TEX_BITS];
    st0_d.func    = func_i;
    st0_d.column  = column_i;
    st0_d.row     = row_i;
    st0_d.side    = wall_side_i;
    st0_d.tx      = (wall_side_i == SIDE_S || wall_side_i == SIDE_E) ? ~tx_raw : tx_raw;
    st0_d.taddr   = texel_addr_i;
    st0_d.tcolor  = texel_color_i;
    st0_d.divisor = distance_i;
    st0_d.num     = height_scale_i[15:0];
    st0_d.rem     = {16'b0, height_scale_i[31:16]};
    st0_d.q       = '0;
    // quotient needs more than 16 bits, or distance is zero
    st0_d.sat     = (distance_i == '0) || ({16'b0, height_scale_i[31:16]} >= distance_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[H_BITS-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0_d;
      for (int s = 1; s <= H_BITS; s++) begin
        logic [32:0] r;
        logic        ge;
        r  = {st_q[s-1].rem, st_q[s-1].num[H_BITS-1]};
        ge = r >= {1'b0, st_q[s-1].divisor};
        st_q[s].func    <= st_q[s-1].func;
        st_q[s].column  <= st_q[s-1].column;
        st_q[s].row     <= st_q[s-1].row;
        st_q[s].side    <= st_q[s-1].side;
        st_q[s].tx      <= st_q[s-1].tx;
        st_q[s].taddr   <= st_q[s-1].taddr;
        st_q[s].tcolor  <= st_q[s-1].tcolor;
        st_q[s].divisor <= st_q[s-1].divisor;
        st_q[s].sat     <= st_q[s-1].sat;
        st_q[s].num     <= {st_q[s-1].num[H_BITS-2:0], 1'b0};
        st_q[s].rem     <= ge ? 32'(r - {1'b0, st_q[s-1].divisor}) : r[31:0];
        st_q[s].q       <= {st_q[s-1].q[H_BITS-2:0], ge};
      end
    end
  end

  assign push_o = en && vld_q[H_BITS];

  always_comb begin
    push_item_o.func   = st_q[H_BITS].func;
    push_item_o.column = st_q[H_BITS].column;
    push_item_o.row    = st_q[H_BITS].row;
    push_item_o.side   = st_q[H_BITS].side;
    push_item_o.tx     = st_q[H_BITS].tx;
    push_item_o.taddr  = st_q[H_BITS].taddr;
    push_item_o.tcolor = st_q[H_BITS].tcolor;
    push_item_o.h      = st_q[H_BITS].sat ? HEIGHT_MAX : st_q[H_BITS].q;
  end

endmodule

### rtl/rwts_queue.sv
// ----------------------------------------------------------------------------
// rwts_queue: short queue between front and back
// Four-entry FIFO of queue items.
// ----------------------------------------------------------------------------
module rwts_queue
  import rwts_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qitem_t push_item_i,
  input  logic   pop_i,
  output qitem_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  qitem_t            ent_q [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o  = ent_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = do_pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

### rtl/rwts_back.sv
// ----------------------------------------------------------------------------
// rwts_back: span test, texture y divider, texture store and result beat
// ----------------------------------------------------------------------------
module rwts_back
  import rwts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ROWS_BITS-1:0]  screen_rows_i,
  input  qitem_t                head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [11:0]           out_column_o,
  output logic [11:0]           out_row_o,
  output logic                  in_wall_o,
  output logic [COLOR_BITS-1:0] color_o
);

  localparam int unsigned NST = TEX_BITS + 2;

  typedef struct packed {
    qitem_t                it;
    logic signed [18:0]    top;
    logic signed [18:0]    bot;
    logic                  inw;
    logic [H_BITS-1:0]     rem;
    logic [TEX_BITS-1:0]   ty;
  } bstage_t;

  bstage_t st_q [0:NST-1];
  bstage_t st0_d;
  logic [NST-1:0] vld_q;
  logic    en;
  logic    ov_q, ov_d;
  logic [11:0]           ocol_q, orow_q;
  logic                  oinw_q;
  logic [COLOR_BITS-1:0] rd_q;
  logic [COLOR_BITS-1:0] mem [0:STORE_DEPTH-1];
  logic signed [18:0]    diff, top_c;

  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && !empty_i;

  // top = (rows - h) / 2, truncated toward zero
  always_comb begin
    diff  = $signed({6'b0, screen_rows_i}) - $signed({3'b0, head_i.h});
    top_c = (diff + $signed({18'b0, diff[18]})) >>> 1;
    st0_d.it    = head_i;
    st0_d.top   = top_c;
    st0_d.bot   = top_c + $signed({3'b0, head_i.h}) - 19'sd1;
    st0_d.inw   = 1'b0;
    st0_d.rem   = '0;
    st0_d.ty    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (en) begin
        vld_q <= {vld_q[NST-2:0], !empty_i};
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (en) ov_d = vld_q[NST-1] && (st_q[NST-1].it.func == FUNC_PIXEL);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [18:0] rs, d;
      logic [H_BITS:0]    r;
      logic               ge;
      st_q[0] <= st0_d;
      // span test and offset into the span
      rs = $signed({7'b0, st_q[0].it.row});
      d  = rs - st_q[0].top;
      st_q[1].it  <= st_q[0].it;
      st_q[1].top <= st_q[0].top;
      st_q[1].bot <= st_q[0].bot;
      st_q[1].inw <= (st_q[0].it.h != '0) && (rs >= st_q[0].top) && (rs <= st_q[0].bot)
                     && ({1'b0, st_q[0].it.row} < screen_rows_i);
      st_q[1].rem <= d[H_BITS-1:0];
      st_q[1].ty  <= '0;
      // ty = offset*TEX_SIZE/h, one quotient bit per stage
      for (int s = 2; s < NST; s++) begin
        r  = {st_q[s-1].rem, 1'b0};
        ge = r >= {1'b0, st_q[s-1].it.h};
        st_q[s].it  <= st_q[s-1].it;
        st_q[s].top <= st_q[s-1].top;
        st_q[s].bot <= st_q[s-1].bot;
        st_q[s].inw <= st_q[s-1].inw;
        st_q[s].rem <= ge ? H_BITS'(r - {1'b0, st_q[s-1].it.h}) : r[H_BITS-1:0];
        st_q[s].ty  <= {st_q[s-1].ty[TEX_BITS-2:0], ge};
      end
      ocol_q <= st_q[NST-1].it.column;
      orow_q <= st_q[NST-1].it.row;
      oinw_q <= st_q[NST-1].inw;
    end
  end

  // texture store: texel writes and pixel reads pass in beat order
  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      if (st_q[NST-1].it.func == FUNC_TEXEL) begin
        mem[{st_q[NST-1].it.side, st_q[NST-1].it.taddr}] <= st_q[NST-1].it.tcolor;
      end else begin
        rd_q <= mem[{st_q[NST-1].it.side, st_q[NST-1].ty, st_q[NST-1].it.tx}];
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_column_o = ocol_q;
  assign out_row_o    = orow_q;
  assign in_wall_o    = oinw_q;
  assign color_o      = oinw_q ? rd_q : '0;

  a_color_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_wall_o) |-> color_o == '0)
    else $error("color outside wall span");

endmodule

### tb/raycast_wall_texel_shader_tb.sv
// ----------------------------------------------------------------------------
// raycast_wall_texel_shader_tb: self-checking bench for the wall texel shader
// Texel beats fill the textures, pixel beats are shaded; every result beat is
// compared against an internal shading predictor, with random bus stalls.
// ----------------------------------------------------------------------------
module raycast_wall_texel_shader_tb;
  import rwts_pkg::*;

  typedef struct packed {
    logic        func;
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] distance;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [1:0]  side;
    logic [11:0] taddr;
    logic [31:0] tcolor;
  } beat_t;

  // packed to match m_tdata, lowest field last
  typedef struct packed {
    logic [31:0] color;
    logic        in_wall;
    logic [11:0] row;
    logic [11:0] column;
  } pix_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;  // column row distance frac_x frac_y side addr color
  logic [0:0]   s_tuser = '0;  // func
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;       // out_column out_row in_wall color

  raycast_wall_texel_shader u_top (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0] tex_mem [STORE_DEPTH];
  bit          tex_written [STORE_DEPTH];  // texels already queued for writing
  logic [31:0] scale_q;
  logic [12:0] rows_q;

  beat_t pending_beats[$];
  pix_t  expected_pixels[$];
  int    mismatches = 0;
  int    pixels_seen = 0;
  int    cycles = 0;
  bit    quiet = 1'b0;    // no stalls in the closing stretch
  bit    hold_src = 1'b0; // sender paused

  // Texel address a pixel reads; returns 1 when the row lies in the span.
  function automatic bit pixel_addr(beat_t b, output logic [13:0] a);
    longint h, top, bot, ys, ye, r, ty;
    logic [15:0] f;
    logic [5:0]  tx;
    if (b.distance == 0) h = 65535;
    else begin
      h = longint'(scale_q) / longint'(b.distance);
      if (h > 65535) h = 65535;
    end
    top = (longint'(rows_q) - h) / 2;
    bot = top + h - 1;
    ys = top < 0 ? 0 : top;
    ye = bot < longint'(rows_q) - 1 ? bot : longint'(rows_q) - 1;
    r = longint'(b.row);
    f = (b.side == SIDE_W || b.side == SIDE_E) ? b.fy : b.fx;
    tx = f[15:10];
    if (b.side == SIDE_S || b.side == SIDE_E) tx = ~tx;
    ty = 0;
    if (h != 0 && r >= ys && r <= ye) begin
      ty = ((r - top) * 64) / h;
      if (ty > 63) ty = 63;
    end
    a = {b.side, ty[5:0], tx};
    return (h != 0 && r >= ys && r <= ye);
  endfunction

  // Shade one beat: updates the texture copy or queues the expected pixel.
  function automatic void shade_beat(beat_t b);
    logic [13:0] a;
    bit hit;
    pix_t p;
    if (b.func == FUNC_TEXEL) begin
      tex_mem[{b.side, b.taddr}] = b.tcolor;
      return;
    end
    hit = pixel_addr(b, a);
    p.column = b.column;
    p.row = b.row;
    p.in_wall = hit;
    p.color = hit ? tex_mem[a] : '0;
    expected_pixels.push_back(p);
  endfunction

  // driver
  int src_gap = 0;
  beat_t cur;

  bit src_taken;
  always @(posedge clk_i) src_taken <= s_tvalid && s_tready;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || src_taken) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0 && !hold_src) begin
          cur = pending_beats.pop_front();
          shade_beat(cur);
          s_tdata <= {2'b0, cur.tcolor, cur.taddr, cur.side, cur.fy, cur.fx,
                      cur.distance, cur.row, cur.column};
          s_tuser <= cur.func;
          s_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end
  // Prediction is done when the beat is offered; the block accepts in order,
  // so the expected queue stays aligned with acceptance.

  // monitor and sink stalls
  int sink_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pix_t got, want;
    cycles <= cycles + 1;
    if (m_tvalid && m_tready && rst_ni) begin
      got = m_tdata[56:0];
      pixels_seen <= pixels_seen + 1;
      if (expected_pixels.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected pixel beat %h", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("pixel mismatch: col %0d/%0d row %0d/%0d wall %b/%b color %h/%h",
                     want.column, got.column, want.row, got.row,
                     want.in_wall, got.in_wall, want.color, got.color);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d pixels outstanding", expected_pixels.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic beat_t texel_beat(logic [1:0] side, logic [11:0] addr,
                                       logic [31:0] color);
    beat_t b;
    b = '0;
    b.func = FUNC_TEXEL;
    b.side = side;
    b.taddr = addr;
    b.tcolor = color;
    b.column = 12'($urandom);
    b.row = 12'($urandom);
    b.distance = $urandom;
    return b;
  endfunction

  function automatic beat_t pixel_beat(logic [31:0] distance, logic [11:0] row);
    beat_t b;
    b.func = FUNC_PIXEL;
    b.column = 12'($urandom);
    b.row = row;
    b.distance = distance;
    b.fx = 16'($urandom);
    b.fy = 16'($urandom);
    b.side = 2'($urandom);
    b.taddr = 12'($urandom);
    b.tcolor = $urandom;
    return b;
  endfunction

  // Queue a beat; a pixel that would read a fresh texel gets a write first.
  function automatic void queue_beat(beat_t b);
    logic [13:0] a;
    if (b.func == FUNC_TEXEL) begin
      tex_written[{b.side, b.taddr}] = 1'b1;
    end else if (pixel_addr(b, a) && !tex_written[a]) begin
      pending_beats.push_back(texel_beat(a[13:12], a[11:0], $urandom));
      tex_written[a] = 1'b1;
    end
    pending_beats.push_back(b);
  endfunction

  task automatic drain();
    wait (pending_beats.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HEIGHT_SCALE) scale_q = val;
    else rows_q = val[12:0];
  endtask

  // random pixel with a distance that lands the wall on screen most times
  function automatic beat_t rand_pixel();
    logic [31:0] d;
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = $urandom;
      2: d = 32'hFFFF_FFFF;
      default: d = $urandom_range(1 << 14, 1 << 20);
    endcase
    return pixel_beat(d, 12'($urandom_range(0, 3) == 0 ? $urandom
                                                      : $urandom_range(0, rows_q)));
  endfunction

  initial begin
    int phase;
    scale_q = 32'd31457280;
    rows_q = 13'd480;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels: zero distance, huge distance, edges of rows and fracs
    queue_beat(pixel_beat(32'd0, 12'd0));
    queue_beat(pixel_beat(32'd0, 12'd479));
    queue_beat(pixel_beat(32'hFFFF_FFFF, 12'd240));
    queue_beat(pixel_beat(32'h0001_0000, 12'hFFF));
    queue_beat(pixel_beat(32'h0001_0000, 12'd225));
    queue_beat(pixel_beat(32'h0001_0000, 12'd254));
    queue_beat(pixel_beat(32'h0001_0000, 12'd255));
    for (int s = 0; s < 4; s++) begin
      beat_t b;
      b = pixel_beat(32'h0000_8000, 12'd240);
      b.side = 2'(s);
      b.fx = s[0] ? 16'hFFFF : 16'h0000;
      b.fy = s[0] ? 16'h0000 : 16'hFFFF;
      queue_beat(b);
    end
    // overwrite a texel
    queue_beat(texel_beat(SIDE_N, 12'hFFF, 32'hFFFF_FFFF));
    queue_beat(texel_beat(SIDE_N, 12'h000, 32'h0000_0000));
    drain();

    // pressure: a run of random pixels queued back to back
    for (int i = 0; i < 20; i++) queue_beat(rand_pixel());
    drain();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(CFG_HEIGHT_SCALE, 32'd0); write_reg(CFG_SCREEN_ROWS, 32'd4096); end
        1: begin write_reg(CFG_HEIGHT_SCALE, 32'hFFFF_FFFF); write_reg(CFG_SCREEN_ROWS, 32'd1); end
        2: begin write_reg(CFG_HEIGHT_SCALE, $urandom); write_reg(CFG_SCREEN_ROWS, 32'h1FFF); end
        3: begin write_reg(CFG_HEIGHT_SCALE, 32'd31457280); write_reg(CFG_SCREEN_ROWS, $urandom_range(1, 4096)); end
        default: begin write_reg(CFG_HEIGHT_SCALE, $urandom_range(1 << 20, 1 << 28));
          write_reg(CFG_SCREEN_ROWS, 32'd480); quiet = 1'b1; end
      endcase
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_beat(texel_beat(2'($urandom), 12'($urandom), $urandom));
        else queue_beat(rand_pixel());
      end
      drain();
    end

    $display("covered %0d shaded pixels over six register settings, texels written ahead of use",
             pixels_seen);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### raycast_wall_texel_shader.f
rtl/rwts_pkg.sv
rtl/rwts_front.sv
rtl/rwts_queue.sv
rtl/rwts_back.sv
rtl/raycast_wall_texel_shader.sv
tb/raycast_wall_texel_shader_tb.sv
